@@ src/hcbd_pkg.sv @@
// Package for the HTTP chunked body decoder: parse phases, status codes,
// character constants, hex helpers and the result record shared by the core and top level.
// No dependencies.
package hcbd_pkg;

    typedef enum logic [2:0] {
        PH_LEAD    = 3'd0,
        PH_DIGITS  = 3'd1,
        PH_IGNORE  = 3'd2,
        PH_DATA    = 3'd3,
        PH_TERM    = 3'd4,
        PH_TRAILER = 3'd5,
        PH_HALT    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_DONE = 2'd1,
        ST_BIG  = 2'd2
    } status_t;

    localparam logic [7:0]  CH_LF   = 8'h0A;
    localparam logic [7:0]  CH_CR   = 8'h0D;
    localparam logic [7:0]  CH_TAB  = 8'h09;
    localparam logic [7:0]  CH_VT   = 8'h0B;
    localparam logic [7:0]  CH_FF   = 8'h0C;
    localparam logic [7:0]  CH_SP   = 8'h20;
    localparam logic [7:0]  CH_SEMI = 8'h3B;
    localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;
    localparam int          HEX_RADIX_BITS = 4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        status_t    status;
    } result_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // A semicolon is not a hex digit, so it falls into the ignored tail like any other.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= "0" && c <= "9") begin
            v = c - 8'h30;
        end else if (c >= "a" && c <= "f") begin
            v = c - 8'h57;
        end else if (c >= "A" && c <= "F") begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SP, CH_TAB, CH_CR, CH_VT, CH_FF};
    endfunction

endpackage

@@ src/hcbd_core.sv @@
// Parse state and step logic of the chunked body decoder.
// Depends on hcbd_pkg.
module hcbd_core #(
    parameter int COUNT_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic [7:0]          in_byte,
    input  logic                restart,
    input  logic [31:0]         max_body_size,
    output hcbd_pkg::result_t   result
);

    localparam int SUM_BITS = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

    hcbd_pkg::phase_t      phase_reg, phase_next, cur_phase;
    hcbd_pkg::status_t     status_reg, status_next, cur_status;
    logic [COUNT_BITS-1:0] chunk_reg, chunk_next, cur_chunk;
    logic [COUNT_BITS-1:0] left_reg, left_next, cur_left, left_dec;
    logic [COUNT_BITS-1:0] total_reg, total_next, cur_total;
    logic                  crlf_reg, crlf_next, cur_crlf;
    logic                  tempty_reg, tempty_next, cur_tempty;
    logic [SUM_BITS-1:0]   sum_ext;
    logic                  too_big;

    // Restart makes the byte see freshly cleared state.
    always_comb begin
        cur_phase  = restart ? hcbd_pkg::PH_LEAD : phase_reg;
        cur_status = restart ? hcbd_pkg::ST_BUSY : status_reg;
        cur_chunk  = restart ? '0 : chunk_reg;
        cur_left   = restart ? '0 : left_reg;
        cur_total  = restart ? '0 : total_reg;
        cur_crlf   = restart ? 1'b0 : crlf_reg;
        cur_tempty = restart ? 1'b1 : tempty_reg;
    end

    assign sum_ext  = SUM_BITS'(cur_total) + SUM_BITS'(cur_chunk);
    assign too_big  = sum_ext > SUM_BITS'(max_body_size);
    assign left_dec = cur_left - COUNT_BITS'(1);

    always_comb begin
        phase_next  = cur_phase;
        status_next = cur_status;
        chunk_next  = cur_chunk;
        left_next   = cur_left;
        total_next  = cur_total;
        crlf_next   = cur_crlf;
        tempty_next = cur_tempty;
        result.out_byte  = 8'd0;
        result.out_valid = 1'b0;
        case (cur_phase)
            hcbd_pkg::PH_LEAD, hcbd_pkg::PH_DIGITS, hcbd_pkg::PH_IGNORE: begin
                if (in_byte == hcbd_pkg::CH_LF) begin
                    if (cur_chunk == '0) begin
                        phase_next  = hcbd_pkg::PH_TRAILER;
                        tempty_next = 1'b1;
                        crlf_next   = 1'b0;
                    end else if (too_big) begin
                        status_next = hcbd_pkg::ST_BIG;
                        phase_next  = hcbd_pkg::PH_HALT;
                    end else begin
                        left_next  = cur_chunk;
                        phase_next = hcbd_pkg::PH_DATA;
                    end
                end else begin
                    if (cur_phase == hcbd_pkg::PH_LEAD && hcbd_pkg::is_blank(in_byte)) begin
                        phase_next = cur_phase;
                    end else if (cur_phase != hcbd_pkg::PH_IGNORE &&
                                 hcbd_pkg::is_hex(in_byte)) begin
                        // Saturate once another digit would shift bits out of the top.
                        if (cur_chunk[COUNT_BITS-1 -: hcbd_pkg::HEX_RADIX_BITS] != '0) begin
                            chunk_next = '1;
                        end else begin
                            chunk_next = {cur_chunk[COUNT_BITS-hcbd_pkg::HEX_RADIX_BITS-1:0],
                                          hcbd_pkg::hex_value(in_byte)};
                        end
                        phase_next = hcbd_pkg::PH_DIGITS;
                    end else begin
                        phase_next = hcbd_pkg::PH_IGNORE;
                    end
                    crlf_next = (in_byte == hcbd_pkg::CH_CR);
                end
            end
            hcbd_pkg::PH_DATA: begin
                result.out_byte  = in_byte;
                result.out_valid = 1'b1;
                total_next = cur_total + COUNT_BITS'(1);
                left_next  = left_dec;
                if (left_dec == '0) begin
                    left_next  = cur_crlf ? COUNT_BITS'(2) : COUNT_BITS'(1);
                    phase_next = hcbd_pkg::PH_TERM;
                end
            end
            hcbd_pkg::PH_TERM: begin
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = hcbd_pkg::PH_LEAD;
                    chunk_next = '0;
                    crlf_next  = 1'b0;
                end
            end
            hcbd_pkg::PH_TRAILER: begin
                if (in_byte == hcbd_pkg::CH_LF) begin
                    if (cur_tempty) begin
                        status_next = hcbd_pkg::ST_DONE;
                        phase_next  = hcbd_pkg::PH_HALT;
                    end
                    tempty_next = 1'b1;
                    crlf_next   = 1'b0;
                end else if (in_byte == hcbd_pkg::CH_CR) begin
                    if (cur_crlf) begin
                        tempty_next = 1'b0;
                    end
                    crlf_next = 1'b1;
                end else begin
                    tempty_next = 1'b0;
                    crlf_next   = 1'b0;
                end
            end
            default: begin
                phase_next = hcbd_pkg::PH_HALT;
            end
        endcase
        result.status = status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= hcbd_pkg::PH_LEAD;
            status_reg <= hcbd_pkg::ST_BUSY;
            chunk_reg  <= '0;
            left_reg   <= '0;
            total_reg  <= '0;
            crlf_reg   <= 1'b0;
            tempty_reg <= 1'b1;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            chunk_reg  <= chunk_next;
            left_reg   <= left_next;
            total_reg  <= total_next;
            crlf_reg   <= crlf_next;
            tempty_reg <= tempty_next;
        end
    end

endmodule

@@ src/http_chunked_body_decoder.sv @@
// Top level of the HTTP chunked body decoder: stream ports, configuration register and
// a two-entry result buffer. Depends on hcbd_pkg and hcbd_core.
//
//   Channel   Direction  Transfer carries
//   s_*       in         tdata: in_byte[7:0]; tuser: restart[0]
//   m_*       out        tdata: out_byte[7:0], status[9:8]; tuser: out_valid[0]
//   cfg_*     in         max_body_size, written when cfg_we is high
//
// One byte is taken per cycle while s_tready is high; every accepted byte yields exactly
// one result transfer, which appears on m_* on the cycle after acceptance unless earlier
// results are still waiting there. The rate is set by the parse state update.
// aresetn is synchronous and active low: it clears the parse state, empties the result
// buffer and loads max_body_size with its reset value. When the result side stalls, a
// skid entry holds one more result, so s_tready falls only once both entries are full.
module http_chunked_body_decoder #(
    parameter int COUNT_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic [0:0]  s_tuser,    // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_byte, [9:8] status, [15:10] zero
    output logic [0:0]  m_tuser,    // [0] out_valid
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    logic              s_fire;
    logic              m_fire;
    logic [31:0]       max_body_reg;
    hcbd_pkg::result_t step_result;
    hcbd_pkg::result_t out_reg, out_next;
    hcbd_pkg::result_t skid_reg, skid_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;

    assign s_tready = !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = out_valid_reg && m_tready;

    // The user must rewrite the register only while the decoder is idle; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_body_reg <= hcbd_pkg::MAX_BODY_RESET;
        end else if (cfg_we) begin
            max_body_reg <= cfg_wdata;
        end
    end

    hcbd_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (s_fire),
        .in_byte       (s_tdata),
        .restart       (s_tuser[0]),
        .max_body_size (max_body_reg),
        .result        (step_result)
    );

    // The output entry is refilled from the skid entry first, so order is kept.
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (m_fire) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (s_fire) begin
            if (!out_valid_reg || m_fire) begin
                out_next       = step_result;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = step_result;
                skid_valid_next = 1'b1;
            end
        end else if (m_fire) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {6'd0, out_reg.status, out_reg.out_byte};
    assign m_tuser[0] = out_reg.out_valid;

endmodule

@@ src/hcbd_checker.sv @@
// Port-level checks for the HTTP chunked body decoder, attached by the bind below.
// Depends only on the top level's ports.
module hcbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result transfer changed");

    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
        else $error("non-payload result carries a nonzero byte");

    a_payload_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[9:8] == 2'd0 && m_tdata[15:10] == 6'd0)
        else $error("payload byte reported with a final status");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ bench/testbench.sv @@
// Self-checking bench for http_chunked_body_decoder: random and directed chunked bodies,
// an in-bench decoder that predicts every result transfer, and random stalls on both sides.
// Depends on hcbd_pkg and the RTL under src/.
module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [31:0] COUNT_ONES = 32'hFFFF_FFFF;
    localparam logic [7:0] BLANKS [5] = '{hcbd_pkg::CH_SP, hcbd_pkg::CH_TAB, hcbd_pkg::CH_CR,
                                          hcbd_pkg::CH_VT, hcbd_pkg::CH_FF};

    typedef struct {
        logic [7:0] data;
        logic       restart;
        logic       drain_first;   // hold this byte back until every result is in
    } feed_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;     // [7:0] in_byte
    logic [0:0]  s_tuser = 1'b0;     // [0] restart
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] out_byte, [9:8] status, [15:10] zero
    logic [0:0]  m_tuser;            // [0] out_valid
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;

    http_chunked_body_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    feed_t             byte_feed[$];
    hcbd_pkg::result_t expected_out[$];
    feed_t             nxt;
    hcbd_pkg::result_t want;
    int                errors = 0;
    int                cycles = 0;
    int                queued = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    logic              next_restart = 1'b0;
    logic              next_drain = 1'b0;

    // Decoder state mirrored by the bench.
    hcbd_pkg::phase_t  dec_phase;
    logic [31:0]       dec_chunk;
    logic [31:0]       dec_left;
    logic [31:0]       dec_total;
    logic              dec_crlf;
    logic              dec_trl_empty;
    hcbd_pkg::status_t dec_status;
    logic [31:0]       max_body;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return c == hcbd_pkg::CH_SP || c == hcbd_pkg::CH_TAB || c == hcbd_pkg::CH_CR
            || c == hcbd_pkg::CH_VT || c == hcbd_pkg::CH_FF;
    endfunction

    function automatic void clear_decoder();
        dec_phase = hcbd_pkg::PH_LEAD;
        dec_chunk = '0;
        dec_left = '0;
        dec_total = '0;
        dec_crlf = 1'b0;
        dec_trl_empty = 1'b1;
        dec_status = hcbd_pkg::ST_BUSY;
    endfunction

    // Advances the mirrored decoder by one input byte and returns the expected result.
    function automatic hcbd_pkg::result_t decode_byte(input logic [7:0] c, input logic rst);
        hcbd_pkg::result_t r;
        int d;
        r.out_byte = 8'd0;
        r.out_valid = 1'b0;
        if (rst) clear_decoder();
        case (dec_phase)
            hcbd_pkg::PH_LEAD, hcbd_pkg::PH_DIGITS, hcbd_pkg::PH_IGNORE: begin
                if (c == hcbd_pkg::CH_LF) begin
                    // End of the size line: zero length opens the trailer.
                    if (dec_chunk == 0) begin
                        dec_phase = hcbd_pkg::PH_TRAILER;
                        dec_trl_empty = 1'b1;
                        dec_crlf = 1'b0;
                    end else if (dec_total > max_body || dec_chunk > max_body - dec_total) begin
                        dec_status = hcbd_pkg::ST_BIG;
                        dec_phase = hcbd_pkg::PH_HALT;
                    end else begin
                        dec_left = dec_chunk;
                        dec_phase = hcbd_pkg::PH_DATA;
                    end
                end else begin
                    d = hex_nibble(c);
                    if (!(dec_phase == hcbd_pkg::PH_LEAD && blank_char(c))) begin
                        if (dec_phase != hcbd_pkg::PH_IGNORE && d >= 0) begin
                            if (dec_chunk > (COUNT_ONES >> 4)) dec_chunk = COUNT_ONES;
                            else dec_chunk = {dec_chunk[27:0], 4'(d)};
                            dec_phase = hcbd_pkg::PH_DIGITS;
                        end else begin
                            dec_phase = hcbd_pkg::PH_IGNORE;
                        end
                    end
                    dec_crlf = (c == hcbd_pkg::CH_CR);
                end
            end
            hcbd_pkg::PH_DATA: begin
                r.out_byte = c;
                r.out_valid = 1'b1;
                dec_total = dec_total + 32'd1;
                dec_left = dec_left - 32'd1;
                if (dec_left == 0) begin
                    dec_left = dec_crlf ? 32'd2 : 32'd1;
                    dec_phase = hcbd_pkg::PH_TERM;
                end
            end
            hcbd_pkg::PH_TERM: begin
                dec_left = dec_left - 32'd1;
                if (dec_left == 0) begin
                    dec_phase = hcbd_pkg::PH_LEAD;
                    dec_chunk = '0;
                    dec_crlf = 1'b0;
                end
            end
            hcbd_pkg::PH_TRAILER: begin
                if (c == hcbd_pkg::CH_LF) begin
                    if (dec_trl_empty) begin
                        dec_status = hcbd_pkg::ST_DONE;
                        dec_phase = hcbd_pkg::PH_HALT;
                    end
                    dec_trl_empty = 1'b1;
                    dec_crlf = 1'b0;
                end else if (c == hcbd_pkg::CH_CR) begin
                    if (dec_crlf) dec_trl_empty = 1'b0;
                    dec_crlf = 1'b1;
                end else begin
                    dec_trl_empty = 1'b0;
                    dec_crlf = 1'b0;
                end
            end
            default: begin
                dec_phase = hcbd_pkg::PH_HALT;
            end
        endcase
        r.status = dec_status;
        return r;
    endfunction

    // ---------------- stimulus builders ----------------

    task automatic push_byte(input logic [7:0] b);
        feed_t f;
        f.data = b;
        f.restart = next_restart;
        f.drain_first = next_drain;
        byte_feed.push_back(f);
        next_restart = 1'b0;
        next_drain = 1'b0;
        queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_eol(input logic crlf);
        if (crlf) push_byte(hcbd_pkg::CH_CR);
        push_byte(hcbd_pkg::CH_LF);
    endtask

    function automatic logic [7:0] hex_char(input int d);
        logic [7:0] c;
        if (d < 10) c = 8'("0" + d);
        else if ($urandom_range(1)) c = 8'("A" + d - 10);
        else c = 8'("a" + d - 10);
        return c;
    endfunction

    task automatic gen_size_line(input int unsigned sz, input logic crlf);
        int nib;
        nib = 1;
        repeat ($urandom_range(2)) push_byte(BLANKS[$urandom_range(4)]);
        while (nib < 8 && (sz >> (4 * nib)) != 0) nib++;
        if ($urandom_range(3) == 0) push_byte("0");
        for (int i = nib - 1; i >= 0; i--) push_byte(hex_char(int'((sz >> (4 * i)) & 15)));
        // Optional chunk extension, sometimes after a stray blank.
        if ($urandom_range(2) == 0) begin
            if ($urandom_range(1)) push_byte(hcbd_pkg::CH_SP);
            push_byte(hcbd_pkg::CH_SEMI);
            repeat ($urandom_range(5, 1)) push_byte(8'($urandom_range(126, 33)));
        end
        push_eol(crlf);
    endtask

    // A well-formed body with random content: data chunks, last chunk, trailer, blank line.
    task automatic gen_body();
        int nch;
        int unsigned sz;
        logic crlf;
        nch = $urandom_range(3);
        next_restart = ($urandom_range(9) != 0);
        for (int k = 0; k <= nch; k++) begin
            if (k == nch) sz = 0;
            else if ($urandom_range(6) == 0) sz = $urandom_range(64, 17);
            else sz = $urandom_range(16, 1);
            crlf = 1'($urandom_range(1));
            gen_size_line(sz, crlf);
            if (sz != 0) begin
                repeat (sz) push_byte(8'($urandom_range(255)));
                // Terminator bytes are skipped unchecked, so garbage is legal there.
                if ($urandom_range(4) == 0) begin
                    repeat (crlf ? 2 : 1) push_byte(8'($urandom_range(255)));
                end else begin
                    push_eol(crlf);
                end
            end
        end
        repeat ($urandom_range(2)) begin
            push_text("X-T:");
            repeat ($urandom_range(4)) push_byte(8'($urandom_range(126, 32)));
            push_eol(1'($urandom_range(1)));
        end
        push_eol(1'($urandom_range(1)));
    endtask

    // Broken or unusual sequences.
    task automatic gen_noise();
        case ($urandom_range(3))
            0: begin
                repeat ($urandom_range(10, 1)) begin
                    next_restart = ($urandom_range(9) == 0);
                    push_byte(8'($urandom_range(255)));
                end
            end
            1: begin
                // Overlong size line, which saturates the chunk length unless its leading digits are zero.
                next_restart = 1'b1;
                repeat ($urandom_range(12, 9)) push_byte(hex_char(int'($urandom_range(15))));
                push_eol(1'($urandom_range(1)));
                repeat ($urandom_range(12, 1)) push_byte(8'($urandom_range(255)));
            end
            2: begin
                // Size line without digits, then a trailer line holding two CRs.
                next_restart = 1'b1;
                push_byte(BLANKS[$urandom_range(4)]);
                push_byte(hcbd_pkg::CH_SEMI);
                push_text("q");
                push_eol(1'($urandom_range(1)));
                push_byte(hcbd_pkg::CH_CR);
                push_byte(hcbd_pkg::CH_CR);
                push_byte(hcbd_pkg::CH_LF);
                push_eol(1'($urandom_range(1)));
            end
            default: begin
                // Body cut off inside its first chunk.
                next_restart = 1'b1;
                gen_size_line($urandom_range(20, 5), 1'($urandom_range(1)));
                repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)));
            end
        endcase
    endtask

    // ---------------- driver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            clear_decoder();
            max_body = hcbd_pkg::MAX_BODY_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_out.push_back(decode_byte(s_tdata, s_tuser[0]));
            end
            if (!s_tvalid || s_tready) begin
                if (byte_feed.size() != 0
                        && !(byte_feed[0].drain_first && expected_out.size() != 0)
                        && $urandom_range(99) >= send_idle_pct) begin
                    nxt = byte_feed.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.data;
                    s_tuser <= nxt.restart;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_out.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transfer: tdata %04h tuser %0d",
                                 m_tdata, m_tuser);
                end else begin
                    want = expected_out.pop_front();
                    if (m_tdata[7:0] !== want.out_byte || m_tuser[0] !== want.out_valid
                            || m_tdata[9:8] !== want.status || m_tdata[15:10] !== 6'd0) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: expected byte %02h valid %0d status %0d",
                                     want.out_byte, want.out_valid, want.status);
                            $display("          got byte %02h valid %0d status %0d pad %02h",
                                     m_tdata[7:0], m_tuser[0], m_tdata[9:8], m_tdata[15:10]);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- test sequence ----------------

    initial begin
        logic [31:0] limits [6];
        int phase_start;
        limits[0] = hcbd_pkg::MAX_BODY_RESET;
        limits[1] = 32'd0;
        limits[2] = COUNT_ONES;
        limits[3] = 32'd40;
        limits[4] = $urandom_range(300, 8);
        limits[5] = hcbd_pkg::MAX_BODY_RESET;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < 6; p++) begin
            // The register is written only with the decoder drained.
            while (byte_feed.size() != 0 || s_tvalid || expected_out.size() != 0)
                @(posedge aclk);
            repeat (4) @(posedge aclk);
            if (p != 0) begin
                cfg_we <= 1'b1;
                cfg_wdata <= limits[p];
                @(posedge aclk);
                cfg_we <= 1'b0;
                max_body = limits[p];
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase

            if (p == 0) begin
                // Every kind of leading blank, an extension, extreme data bytes,
                // a trailer line with a lone CR, and a byte after completion.
                next_restart = 1'b1;
                push_byte(hcbd_pkg::CH_SP);
                push_byte(hcbd_pkg::CH_TAB);
                push_byte(hcbd_pkg::CH_VT);
                push_byte(hcbd_pkg::CH_FF);
                push_byte(hcbd_pkg::CH_CR);
                push_text("2;");
                push_byte(hcbd_pkg::CH_LF);
                push_byte(8'h00);
                push_byte(8'hFF);
                push_byte(hcbd_pkg::CH_LF);
                push_text("0");
                push_byte(hcbd_pkg::CH_LF);
                push_byte(hcbd_pkg::CH_CR);
                push_byte(hcbd_pkg::CH_LF);
                push_text("X");
                // Saturating size line that trips the too-large check.
                next_restart = 1'b1;
                push_text("FFFFFFFFF");
                push_eol(1'b1);
            end

            phase_start = queued;
            gen_body();
            next_drain = 1'b1;
            while (queued - phase_start < 120) begin
                if ($urandom_range(6) == 0) gen_noise();
                else gen_body();
            end
        end

        while (byte_feed.size() != 0 || s_tvalid || expected_out.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_out.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/hcbd_pkg.sv
src/hcbd_core.sv
src/http_chunked_body_decoder.sv
src/hcbd_checker.sv
bench/testbench.sv
